### hdl/gsms_pkg.sv
// Shared types, constants and helpers for the graphics screen mode select block.
// No dependencies; compile before every other file of the block.
package gsms_pkg;

  localparam int ByteW   = 8;
  localparam int DivsrW  = 4;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int PlaneW  = 5;
  localparam int PmaxW   = 6;

  localparam logic [ByteW-1:0] KeepByte = 8'hFF;

  // graphics controller mode command bytes
  localparam logic [ByteW-1:0] GdcMode0Odd  = 8'h40;
  localparam logic [ByteW-1:0] GdcMode0Even = 8'h80;
  localparam logic [ByteW-1:0] GdcMode1High = 8'h60;
  localparam logic [ByteW-1:0] GdcMode1Low  = 8'hA0;
  localparam logic [ByteW-1:0] GdcMode2     = 8'hE0;
  localparam logic [ByteW-1:0] GdcMode3     = 8'hC0;

  localparam logic [1:0] PalSixteen = 2'd2;

  typedef enum logic [1:0] {
    SCR_MODE0 = 2'd0,
    SCR_MODE1 = 2'd1,
    SCR_MODE2 = 2'd2,
    SCR_MODE3 = 2'd3
  } scr_mode_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } act_e;

  typedef enum logic {
    REG_PALETTE = 1'b0,
    REG_EXT     = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    logic [1:0] palette_mode;
    logic       extended_modes_allowed;
  } cfg_t;

  // number of color bits per bank: 4 for sixteen colors, 3 otherwise
  function automatic logic [2:0] color_bits(input logic pal16);
    color_bits = pal16 ? 3'd4 : 3'd3;
  endfunction

  // divisor that splits the active byte into bank position and page
  function automatic logic [DivsrW-1:0] split_divisor(input scr_mode_e mode,
                                                     input logic pal16);
    logic [DivsrW-1:0] d;
    unique case (mode)
      SCR_MODE0: d = DivsrW'(2);
      SCR_MODE1: d = pal16 ? DivsrW'(8) : DivsrW'(6);
      SCR_MODE2: d = pal16 ? DivsrW'(4) : DivsrW'(3);
      SCR_MODE3: d = DivsrW'(1);
      default:   d = DivsrW'(1);
    endcase
    split_divisor = d;
  endfunction

endpackage

### hdl/gsms_req_if.sv
// Request channel: valid/ready plus the four request bytes.
// Depends on gsms_pkg.
interface gsms_req_if;
  logic                      valid;
  logic                      ready;
  logic [gsms_pkg::ByteW-1:0] req_mode;
  logic [gsms_pkg::ByteW-1:0] req_switch;
  logic [gsms_pkg::ByteW-1:0] req_active;
  logic [gsms_pkg::ByteW-1:0] req_display;

  modport source(output valid, req_mode, req_switch, req_active, req_display,
                 input ready);
  modport sink(input valid, req_mode, req_switch, req_active, req_display,
               output ready);
endinterface

### hdl/gsms_rsp_if.sv
// Result channel: valid/ready plus status, display action, mode byte, page.
// Depends on gsms_pkg.
interface gsms_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [1:0]                display_action;
  logic [gsms_pkg::ByteW-1:0] gdc_mode_byte;
  logic                      access_page_out;

  modport source(output valid, status, display_action, gdc_mode_byte, access_page_out,
                 input ready);
  modport sink(input valid, status, display_action, gdc_mode_byte, access_page_out,
               output ready);
endinterface

### hdl/graphics_screen_mode_select_core.sv
// Top level of the graphics screen mode select block.
// Depends on gsms_pkg, gsms_req_if, gsms_rsp_if, gsms_apb and gsms_div.
//
// Usage:
//   req_i carries one screen-set request item (mode, switch, active and
//   display bytes; 0xFF in a byte keeps the current value). rsp_o returns
//   one result item per request: status, display action, graphics mode
//   command byte and access page. The APB port holds palette mode
//   (address 0) and the extended-mode capability bit (address 4); write
//   them only while no request is in flight.
// Sequence:
//   After acceptance an item takes two steps of the compare-and-subtract
//   unit that splits the active byte into bank position and access page;
//   its done flag then advances the sequencer, which checks the request,
//   commits state and loads the result register. The next item is accepted
//   in the cycle after the commit, and only one item is in work at a time.
// Reset:
//   Clears the configuration, mode, position and pages, sets the plane mask
//   to one and empties the result register.
// Stall:
//   A finished result waits in the result register; the next request is
//   accepted meanwhile and its commit waits until that register frees up.
module graphics_screen_mode_select_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gsms_req_if.sink                      req_i,
  gsms_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsms_pkg::ApbAddrW-1:0] paddr,
  input  logic [gsms_pkg::ApbDataW-1:0] pwdata,
  output logic [gsms_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import gsms_pkg::*;

  cfg_t cfg;

  gsms_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic       pal16;
  logic [2:0] cbits;
  assign pal16 = cfg.palette_mode == PalSixteen;
  assign cbits = color_bits(pal16);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  seq_state_e state_q, state_d;
  logic       req_fire, fin_fire, div_done, rsp_free;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_o.valid || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    fin_fire    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_d = S_FIN;
      end
      S_FIN: begin
        // hold the commit until the result register can take the item
        if (rsp_free) begin
          fin_fire = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request capture; the effective mode is resolved at acceptance so the
  // divider can start with the right divisor.
  // ---------------------------------------------------------------------
  scr_mode_e screen_mode_q;
  logic [2:0] bank_pos_q;
  logic       access_page_q;
  logic [PlaneW-1:0] plane_mask_q;
  logic       display_page_q;

  logic [ByteW-1:0] rmode_q, rsw_q, ract_q, rdisp_q;
  scr_mode_e        mode_q, mode_in;

  assign mode_in = (req_i.req_mode == KeepByte) ? screen_mode_q
                                                 : scr_mode_e'(req_i.req_mode[1:0]);

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rmode_q <= req_i.req_mode;
      rsw_q   <= req_i.req_switch;
      ract_q  <= req_i.req_active;
      rdisp_q <= req_i.req_display;
      mode_q  <= mode_in;
    end
  end

  // quot: page count, where two means two or more
  logic [1:0]        quot;
  logic [DivsrW-1:0] rem;

  gsms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_fire),
    .dividend_i (req_i.req_active),
    .divisor_i  (split_divisor(mode_in, pal16)),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // ---------------------------------------------------------------------
  // Checks and new state values
  // ---------------------------------------------------------------------
  logic mode_rej, mode_chg, act_keep, disp_keep;
  logic page_bad, disp_bad, plane_bad, success, mono;
  logic [2:0] pos_new;
  logic       page_new;
  logic [PlaneW-1:0] plane;
  logic [3:0]        disp_hi;
  logic              disp_new;
  logic [PmaxW-1:0]  pmax;
  logic [PmaxW-1:0]  plane_solo;
  act_e              action;
  logic [ByteW-1:0]  gbyte;

  // reject modes 4..254, and 2..254 without the extended capability
  assign mode_rej = (rmode_q != KeepByte) &&
                    ((rmode_q >= ByteW'(4)) ||
                     ((rmode_q >= ByteW'(2)) && !cfg.extended_modes_allowed));
  assign mode_chg = mode_q != screen_mode_q;

  always_comb begin
    if (rsw_q == KeepByte) action = ACT_NONE;
    else if (rsw_q[1])     action = ACT_STOP;
    else                   action = ACT_START;
  end

  // active byte: kept values clear on a mode change
  assign act_keep = ract_q == KeepByte;
  assign page_bad = !act_keep && quot[1];
  assign pos_new  = act_keep ? (mode_chg ? 3'd0 : bank_pos_q) : rem[2:0];
  assign page_new = act_keep ? (mode_chg ? 1'b0 : access_page_q) : quot[0];

  // display byte: plane mask below, display page above
  assign disp_keep = rdisp_q == KeepByte;
  assign plane     = pal16 ? rdisp_q[PlaneW-1:0] : {1'b0, rdisp_q[PlaneW-2:0]};
  assign disp_hi   = pal16 ? {1'b0, rdisp_q[7:5]} : rdisp_q[7:4];
  assign disp_bad  = |disp_hi[3:1];
  assign mono      = (mode_q == SCR_MODE1) || (mode_q == SCR_MODE2);

  always_comb begin
    pmax = PmaxW'(1);
    if (mono) pmax = pmax << cbits;
    if (!mode_q[1]) pmax = pmax << 1;
  end

  assign plane_solo = PmaxW'(1) << cbits;
  assign plane_bad  = ({1'b0, plane} > pmax) && ({1'b0, plane} != plane_solo);
  assign disp_new   = disp_keep ? (mode_chg ? 1'b0 : display_page_q) : disp_hi[0];

  assign success = !mode_rej && !page_bad &&
                   (disp_keep || (!disp_bad && !plane_bad));

  always_comb begin
    unique case (mode_q)
      SCR_MODE0: gbyte = (pos_new != 3'd0) ? GdcMode0Odd : GdcMode0Even;
      SCR_MODE1: gbyte = (pos_new >= cbits) ? GdcMode1High : GdcMode1Low;
      SCR_MODE2: gbyte = GdcMode2;
      SCR_MODE3: gbyte = GdcMode3;
      default:   gbyte = GdcMode3;
    endcase
    gbyte[4] = disp_new;
  end

  // writes that happen before a later failing check stay in place
  logic wr_act, wr_dpage, wr_plane;
  assign wr_act   = fin_fire && !mode_rej && !page_bad;
  assign wr_dpage = wr_act && (disp_keep ? mode_chg : !disp_bad);
  assign wr_plane = wr_act && (disp_keep ? mode_chg : (!disp_bad && !plane_bad));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_mode_q  <= SCR_MODE0;
      bank_pos_q     <= '0;
      access_page_q  <= 1'b0;
      plane_mask_q   <= PlaneW'(1);
      display_page_q <= 1'b0;
    end else begin
      if (wr_act) begin
        bank_pos_q    <= pos_new;
        access_page_q <= page_new;
      end
      if (wr_dpage) display_page_q <= disp_new;
      if (wr_plane) plane_mask_q <= disp_keep ? PlaneW'(1) : plane;
      if (fin_fire && success) screen_mode_q <= mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic             rsp_valid_q, rsp_status_q, rsp_page_q;
  act_e             rsp_act_q;
  logic [ByteW-1:0] rsp_gbyte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fin_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      rsp_status_q <= !success;
      rsp_act_q    <= mode_rej ? ACT_NONE : action;
      rsp_gbyte_q  <= success ? gbyte : '0;
      rsp_page_q   <= success ? page_new : 1'b0;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.display_action  = rsp_act_q;
  assign rsp_o.gdc_mode_byte   = rsp_gbyte_q;
  assign rsp_o.access_page_out = rsp_page_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_DIV) && !req_i.ready)
    else $error("accepted item did not start the divide");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && mode_rej) |=> $stable(screen_mode_q) && $stable(bank_pos_q) &&
      $stable(access_page_q) && $stable(plane_mask_q) && $stable(display_page_q))
    else $error("rejected mode changed stored state");

  a_error_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.gdc_mode_byte == '0) &&
      !rsp_o.access_page_out)
    else $error("error result carries a mode byte or page");

endmodule

### hdl/gsms_apb.sv
// APB-style configuration registers: palette mode and extended-mode capability.
// Depends on gsms_pkg.
module gsms_apb (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gsms_pkg::ApbAddrW-1:0]  paddr,
  input  logic [gsms_pkg::ApbDataW-1:0]  pwdata,
  output logic [gsms_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output gsms_pkg::cfg_t                 cfg_o
);
  import gsms_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PALETTE: cfg_q.palette_mode           <= pwdata[1:0];
        REG_EXT:     cfg_q.extended_modes_allowed <= pwdata[0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PALETTE: prdata[1:0] = cfg_q.palette_mode;
      REG_EXT:     prdata[0]   = cfg_q.extended_modes_allowed;
      default:     prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/gsms_div.sv
// Compare-and-subtract unit for the active-byte split: two steps give the bank
// position and whether the page is 0, 1 or too large. Depends on gsms_pkg.
module gsms_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gsms_pkg::ByteW-1:0]   dividend_i,
  input  logic [gsms_pkg::DivsrW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [1:0]                   quot_o,
  output logic [gsms_pkg::DivsrW-1:0]  rem_o
);
  import gsms_pkg::*;

  logic [ByteW-1:0]  rem_q, rem_d, divisor_ext;
  logic [DivsrW-1:0] divisor_q;
  logic [1:0]        quot_q, quot_d;
  logic              step_q, busy_q, done_q;
  logic              ge;

  // subtract the divisor at most once per step; a count of two flags a page that is too large
  assign divisor_ext = {{(ByteW-DivsrW){1'b0}}, divisor_q};
  assign ge          = rem_q >= divisor_ext;
  assign rem_d       = ge ? (rem_q - divisor_ext) : rem_q;
  assign quot_d      = quot_q + {1'b0, ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= 1'b1;
        if (step_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i;
      quot_q    <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[DivsrW-1:0];

endmodule

### test/graphics_screen_mode_select_core_tb.sv
// Testbench for graphics_screen_mode_select_core: directed table, then random screen-set
// requests checked against an in-bench predictor of status, action, mode byte and page.
// Depends on gsms_pkg, gsms_req_if, gsms_rsp_if and the core RTL.
module graphics_screen_mode_select_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsms_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int NumPhases    = 6;
  localparam int PhaseItems   = 240;
  localparam int NumDirected  = 26;

  typedef struct packed {
    logic [ByteW-1:0] mode;
    logic [ByteW-1:0] sw;
    logic [ByteW-1:0] act;
    logic [ByteW-1:0] disp;
  } screen_req_t;

  typedef struct packed {
    logic             status;
    act_e             action;
    logic [ByteW-1:0] mode_byte;
    logic             page;
  } screen_rsp_t;

  // one row of the directed table; the typed result applies only where has_exp is set
  typedef struct packed {
    logic [1:0]       pal;
    logic             ext;
    logic [ByteW-1:0] mode;
    logic [ByteW-1:0] sw;
    logic [ByteW-1:0] act;
    logic [ByteW-1:0] disp;
    logic             has_exp;
    logic             status;
    act_e             action;
    logic [ByteW-1:0] mode_byte;
    logic             page;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  gsms_req_if req_if ();
  gsms_rsp_if rsp_if ();

  graphics_screen_mode_select_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predictor copy of the configuration and of the screen state
  logic [1:0] cfg_pal;
  logic       cfg_ext;
  logic [1:0] st_mode;
  logic [2:0] st_pos;
  logic       st_page;
  logic [4:0] st_plane;
  logic       st_disp;

  screen_rsp_t expected_results[$];
  int unsigned fails      = 0;
  int unsigned n_checked  = 0;
  int unsigned n_rejected = 0;
  int unsigned n_settings = 0;
  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;

  dir_row_t dir_tab [NumDirected];

  // divisor that splits the active byte for a given mode
  function automatic int unsigned bank_span(input logic [1:0] m, input int unsigned cb);
    case (scr_mode_e'(m))
      SCR_MODE0: return 2;
      SCR_MODE1: return 2 * cb;
      SCR_MODE2: return cb;
      default:   return 1;
    endcase
  endfunction

  // largest legal plane mask besides the single top plane
  function automatic int unsigned plane_limit(input logic [1:0] m, input int unsigned cb);
    int unsigned lim;
    lim = 1;
    if (m == SCR_MODE1 || m == SCR_MODE2) lim = lim << cb;
    if (!m[1]) lim = lim << 1;
    return lim;
  endfunction

  // Compute the result of one request and advance the predicted state; a rejected
  // request returns early and leaves whatever was already stored.
  function automatic screen_rsp_t predict_screen_set(input screen_req_t r);
    screen_rsp_t res;
    int unsigned cb, mode, pos, pg, dp, pl;
    res        = '0;
    res.status = 1'b1;
    res.action = ACT_NONE;
    cb = (cfg_pal == PalSixteen) ? 4 : 3;
    if (r.mode == KeepByte) begin
      mode = st_mode;
    end else begin
      if (r.mode >= SCR_MODE2 && !cfg_ext) return res;
      mode = r.mode;
    end
    if (mode > SCR_MODE3) return res;

    // the switch takes effect even if a later check fails
    if (r.sw != KeepByte) res.action = r.sw[1] ? ACT_STOP : ACT_START;

    if (r.act == KeepByte) begin
      if (mode != st_mode) begin
        st_pos  = '0;
        st_page = 1'b0;
      end
      pos = st_pos;
    end else begin
      pos = r.act % bank_span(mode[1:0], cb);
      pg  = r.act / bank_span(mode[1:0], cb);
      if (pg >= 2) return res;
      st_pos  = pos[2:0];
      st_page = pg[0];
    end

    if (r.disp == KeepByte) begin
      if (mode != st_mode) begin
        st_plane = 5'd1;
        st_disp  = 1'b0;
      end
      dp = st_disp;
    end else begin
      pl = r.disp & ((2 << cb) - 1);
      dp = r.disp >> (cb + 1);
      if (dp >= 2) return res;
      st_disp = dp[0];
      if (pl > plane_limit(mode[1:0], cb) && pl != (1 << cb)) return res;
      st_plane = pl[4:0];
    end

    st_mode = mode[1:0];
    case (scr_mode_e'(mode[1:0]))
      SCR_MODE0: res.mode_byte = (pos != 0) ? GdcMode0Odd : GdcMode0Even;
      SCR_MODE1: res.mode_byte = (pos >= cb) ? GdcMode1High : GdcMode1Low;
      SCR_MODE2: res.mode_byte = GdcMode2;
      default:   res.mode_byte = GdcMode3;
    endcase
    res.mode_byte = res.mode_byte | (ByteW'(dp[0]) << 4);
    res.status    = 1'b0;
    res.page      = st_page;
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Build a request: mostly well formed for the mode it will run in, the rest raw bytes.
  function automatic screen_req_t gen_request();
    screen_req_t r;
    int unsigned cb, span, lim, k, pl;
    logic [1:0]  eff;
    cb = (cfg_pal == PalSixteen) ? 4 : 3;
    k  = $urandom_range(0, 99);
    if (k < 15) r.mode = KeepByte;
    else if (k < 88) r.mode = ByteW'($urandom_range(0, cfg_ext ? 3 : 1));
    else r.mode = ByteW'($urandom_range(0, 255));
    eff = (r.mode == KeepByte) ? st_mode : r.mode[1:0];

    r.sw = ($urandom_range(0, 99) < 30) ? KeepByte : ByteW'($urandom_range(0, 255));

    k    = $urandom_range(0, 99);
    span = bank_span(eff, cb);
    if (k < 25) r.act = KeepByte;
    else if (k < 80) r.act = ByteW'($urandom_range(0, 1) * span + $urandom_range(0, span - 1));
    else r.act = ByteW'($urandom_range(0, 255));

    k   = $urandom_range(0, 99);
    lim = plane_limit(eff, cb);
    if (lim > (2 << cb) - 1) lim = (2 << cb) - 1;
    pl  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, lim) : (1 << cb);
    if (k < 25) r.disp = KeepByte;
    else if (k < 80) r.disp = ByteW'(($urandom_range(0, 1) << (cb + 1)) | pl);
    else r.disp = ByteW'($urandom_range(0, 255));
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record what it should produce.
  task automatic offer_request(input screen_req_t r, input bit typed,
                               input screen_rsp_t typed_rsp);
    screen_rsp_t p;
    int unsigned gap;
    req_if.valid       <= 1'b1;
    req_if.req_mode    <= r.mode;
    req_if.req_switch  <= r.sw;
    req_if.req_active  <= r.act;
    req_if.req_display <= r.disp;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    p = predict_screen_set(r);
    expected_results.push_back(typed ? typed_rsp : p);
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait until every outstanding result is back, then let the block settle.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then an idle phase with select dropped
  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] pal, input logic ext);
    wait_idle();
    apb_write(REG_PALETTE, ApbDataW'(pal));
    apb_write(REG_EXT, ApbDataW'(ext));
    cfg_pal = pal;
    cfg_ext = ext;
    n_settings++;
  endtask

  // Result side: ready with random gaps, plus one long hold-off on request.
  initial begin
    int unsigned g;
    @(posedge clk_i iff rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        g = pick_gap();
        if (g != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk_i) begin
    screen_rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with no request outstanding");
        fails++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.status) n_rejected++;
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
          fails++;
        end
        if (rsp_if.display_action !== want.action) begin
          $error("display_action mismatch: expected %0d, got %0d",
                 want.action, rsp_if.display_action);
          fails++;
        end
        if (rsp_if.gdc_mode_byte !== want.mode_byte) begin
          $error("gdc_mode_byte mismatch: expected %0h, got %0h",
                 want.mode_byte, rsp_if.gdc_mode_byte);
          fails++;
        end
        if (rsp_if.access_page_out !== want.page) begin
          $error("access_page_out mismatch: expected %0d, got %0d",
                 want.page, rsp_if.access_page_out);
          fails++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [1:0] pal;
    logic       ext;
    screen_rsp_t typed_rsp;

    // columns: pal ext | mode switch active display | typed? status action byte page
    dir_tab = '{
      // reset state kept whole: mode 0, even bank, page 0
      '{2'd0, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, ACT_NONE,  8'h80, 1'b0},
      // extended mode without the capability, and an out-of-range mode
      '{2'd0, 1'b0, 8'h02, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hfe, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      // start, odd bank; then stop, page 1 on both sides
      '{2'd0, 1'b0, 8'h00, 8'h00, 8'h01, 8'h01, 1'b1, 1'b0, ACT_START, 8'h40, 1'b0},
      '{2'd0, 1'b0, 8'h00, 8'h02, 8'h02, 8'h10, 1'b1, 1'b0, ACT_STOP,  8'h90, 1'b1},
      // switch reported although the active page is too large
      '{2'd0, 1'b0, 8'hff, 8'h00, 8'h04, 8'hff, 1'b1, 1'b1, ACT_START, 8'h00, 1'b0},
      // display page too large, then an illegal plane mask
      '{2'd0, 1'b0, 8'hff, 8'hff, 8'hff, 8'h20, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hff, 8'hff, 8'hff, 8'h07, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      // single top plane is always legal
      '{2'd0, 1'b0, 8'hff, 8'hff, 8'hff, 8'h08, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      // mode change with display kept, then keep active with a full mask
      '{2'd0, 1'b0, 8'h01, 8'hff, 8'h0b, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hff, 8'hff, 8'hff, 8'h1f, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hff, 8'h55, 8'h00, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hff, 8'hfd, 8'hff, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd0, 1'b0, 8'hff, 8'hfe, 8'hff, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      // sixteen colors with the capability
      '{2'd2, 1'b1, 8'h02, 8'hff, 8'h07, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h03, 8'hff, 8'h01, 8'h20, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h03, 8'hff, 8'h02, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h04, 8'h00, 8'hff, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h01, 8'hff, 8'h0f, 8'h3f, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h02, 8'hff, 8'hff, 8'h10, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'h02, 8'hff, 8'hff, 8'h11, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd2, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      // palette code 3 falls back to eight colors; kept mode 2 passes without capability
      '{2'd3, 1'b0, 8'hff, 8'h02, 8'h05, 8'hff, 1'b0, 1'b0, ACT_NONE,  8'h00, 1'b0},
      '{2'd3, 1'b0, 8'h03, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd3, 1'b0, 8'h00, 8'hff, 8'hfe, 8'hff, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0},
      '{2'd3, 1'b0, 8'h00, 8'hff, 8'hff, 8'hfe, 1'b1, 1'b1, ACT_NONE,  8'h00, 1'b0}
    };

    // drive every input to a known value before the first edge
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.req_mode    = KeepByte;
    req_if.req_switch  = KeepByte;
    req_if.req_active  = KeepByte;
    req_if.req_display = KeepByte;
    rsp_if.ready       = 1'b0;

    cfg_pal  = 2'd0;
    cfg_ext  = 1'b0;
    st_mode  = SCR_MODE0;
    st_pos   = '0;
    st_page  = 1'b0;
    st_plane = 5'd1;
    st_disp  = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; change the configuration only with the block drained
    for (int i = 0; i < NumDirected; i++) begin
      if (dir_tab[i].pal != cfg_pal || dir_tab[i].ext != cfg_ext)
        set_config(dir_tab[i].pal, dir_tab[i].ext);
      typed_rsp = '{dir_tab[i].status, dir_tab[i].action, dir_tab[i].mode_byte,
                    dir_tab[i].page};
      offer_request('{dir_tab[i].mode, dir_tab[i].sw, dir_tab[i].act, dir_tab[i].disp},
                    dir_tab[i].has_exp, typed_rsp);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       begin pal = 2'd0; ext = 1'b1; end
        1:       begin pal = 2'd2; ext = 1'b1; end
        2:       begin pal = 2'd3; ext = 1'b1; end
        3:       begin pal = 2'd1; ext = 1'b0; end
        4:       begin pal = 2'd2; ext = 1'b0; end
        default: begin pal = 2'($urandom_range(0, 3)); ext = 1'($urandom_range(0, 1)); end
      endcase
      set_config(pal, ext);
      // phase 4 runs with no gaps on either side
      no_idle = (p == 4);
      for (int i = 0; i < PhaseItems; i++) begin
        // stall the result side for a long stretch while requests keep coming
        if (p == 1 && i == 40) hold_request = 1'b1;
        // pause the request side until everything is back
        if (p == 2 && i == PhaseItems / 2) wait_idle();
        offer_request(gen_request(), 1'b0, '0);
      end
    end

    wait_idle();

    $display("checked %0d result items (%0d rejected requests) under %0d register settings",
             n_checked, n_rejected, n_settings);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gsms_pkg.sv
hdl/gsms_req_if.sv
hdl/gsms_rsp_if.sv
hdl/gsms_apb.sv
hdl/gsms_div.sv
hdl/graphics_screen_mode_select_core.sv
test/graphics_screen_mode_select_core_tb.sv
